// ----- src/oxygen_window_averager_defines.svh -----
// Assertion macros for the window averager
`ifndef OXYGEN_WINDOW_AVERAGER_DEFINES_SVH
`define OXYGEN_WINDOW_AVERAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define OWA_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owa implication check failed");

// Next-cycle implication, sampled on clk, off during reset
`define OWA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owa next-cycle check failed");

`endif

// ----- src/owa_pkg.sv -----
`default_nettype none

package owa_pkg;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 15;
  localparam int SUM_W    = 22;
  localparam int WIN_W    = 7;
  localparam int KEY_W    = 8;
  localparam int KN_W     = 8;
  localparam int KD_W     = 11;
  localparam int NUM_W    = SUM_W + KN_W;
  localparam int DEN_W    = WIN_W + KD_W;
  localparam int MEAN_W   = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd20;
  localparam logic [KEY_W-1:0] KEY_RESET    = 8'd0;

  localparam logic [KN_W-1:0] KN_DEFAULT = 8'd209;
  localparam logic [KD_W-1:0] KD_DEFAULT = 11'd1200;
  localparam logic [KD_W-1:0] KD_CODED   = 11'd1000;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] whole_part;
    logic [BYTE_W-1:0] tenths_part;
    logic [BYTE_W-1:0] hundredths_part;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_concentration;
    logic              window_error;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- src/owa_ram.sv -----
`default_nettype none

module owa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 100
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/owa_div.sv -----
`default_nettype none

module owa_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [owa_pkg::NUM_W-1:0] numer,
  input  wire logic [owa_pkg::DEN_W-1:0] denom,
  output logic      [owa_pkg::NUM_W-1:0] quotient,
  output owa_pkg::div_status_t           status
);

  import owa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
      rem_nxt = '0;
      quo_nxt = numer;
      den_nxt = denom;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      rem_nxt  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;

endmodule

`default_nettype wire

// ----- src/oxygen_window_averager.sv -----
// Boxcar moving average of oxygen readings. Each transfer on the input side
// carries one reading as three bytes; the block keeps the last window_length
// readings (at most MAX_WINDOW) in a single-port-per-side ring RAM with a
// running sum and a warm-up count, and returns one result per reading: the
// window mean scaled by the calibration key, in hundredths of a percent,
// rounded down. A valid window passes through a RAM read, a read-modify-write
// update, a multiply and the one-bit-per-cycle restoring divider that sets the
// rate. An invalid window (0 or above MAX_WINDOW) goes straight to the result
// stage with the error flag and leaves the history alone. One reading is in
// flight at a time; the result register lets the next reading enter while a
// result waits. Writing window_length restarts the history; writing key_code
// rescales from the next result on. No clearing pass is needed after reset.
`default_nettype none

module oxygen_window_averager #(
  parameter int MAX_WINDOW = 100
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire owa_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output owa_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [owa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [owa_pkg::KEY_W-1:0]     cfg_data
);

  import owa_pkg::*;

  `include "oxygen_window_averager_defines.svh"

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [WIN_W-1:0]    window_length_r;
  logic [KEY_W-1:0]    key_code_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [WIN_W-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]       write_slot_r, write_slot_nxt;
  logic [AW-1:0]       slot_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [MEAN_W-1:0]   res_mean_r, res_mean_nxt;
  logic                res_err_r, res_err_nxt;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                in_xfer, out_xfer, cfg_xfer;
  logic                win_ok;
  logic [AW-1:0]       slot_sel;
  logic [SAMPLE_W-1:0] sample_in;
  logic                fill_full;
  logic [SAMPLE_W-1:0] old_sample;
  logic [WIN_W-1:0]    slot_inc;
  logic [KN_W-1:0]     kn;
  logic [KD_W-1:0]     kd;
  logic [NUM_W-1:0]    numer;
  logic [DEN_W-1:0]    denom;
  logic [SAMPLE_W-1:0] ram_rd_data;
  logic [NUM_W-1:0]    quotient;
  div_status_t         div_status;
  logic                load_out;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_xfer  = out_valid_r && !out_stall;

  assign win_ok = (window_length_r != '0) && (window_length_r <= WIN_W'(MAX_WINDOW));

  assign sample_in = SAMPLE_W'(in_item.whole_part) * SAMPLE_W'(100)
                   + SAMPLE_W'(in_item.tenths_part) * SAMPLE_W'(10)
                   + SAMPLE_W'(in_item.hundredths_part);

  assign slot_sel   = (WIN_W'(write_slot_r) >= window_length_r) ? '0 : write_slot_r;
  assign fill_full  = (fill_r >= window_length_r);
  assign old_sample = fill_full ? ram_rd_data : '0;
  assign slot_inc   = WIN_W'(slot_r) + 1'b1;

  assign kn    = (key_code_r == '0) ? KN_DEFAULT : key_code_r;
  assign kd    = (key_code_r == '0) ? KD_DEFAULT : KD_CODED;
  assign numer = NUM_W'(sum_r) * NUM_W'(kn);
  assign denom = DEN_W'(fill_r) * DEN_W'(kd);

  owa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (state_r == S_READ),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  owa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_MUL),
    .numer    (numer),
    .denom    (denom),
    .quotient (quotient),
    .status   (div_status)
  );

  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    fill_nxt       = fill_r;
    write_slot_nxt = write_slot_r;
    res_mean_nxt   = res_mean_r;
    res_err_nxt    = res_err_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (win_ok) begin
            state_nxt = S_READ;
          end else begin
            res_mean_nxt = '0;
            res_err_nxt  = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        sum_nxt        = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        fill_nxt       = fill_full ? window_length_r : fill_r + 1'b1;
        write_slot_nxt = (slot_inc >= window_length_r) ? '0 : AW'(slot_inc);
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          res_mean_nxt = (quotient[NUM_W-1:MEAN_W] != '0) ? MEAN_MAX
                                                          : quotient[MEAN_W-1:0];
          res_err_nxt  = 1'b0;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_xfer && cfg_index == REG_WINDOW) begin
      sum_nxt        = '0;
      fill_nxt       = '0;
      write_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      window_length_r <= WINDOW_RESET;
      key_code_r      <= KEY_RESET;
      sum_r           <= '0;
      fill_r          <= '0;
      write_slot_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      fill_r       <= fill_nxt;
      write_slot_r <= write_slot_nxt;
      if (cfg_xfer) begin
        case (cfg_index)
          REG_WINDOW: window_length_r <= cfg_data[WIN_W-1:0];
          REG_KEY:    key_code_r      <= cfg_data;
          default:    ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      slot_r   <= slot_sel;
      sample_r <= sample_in;
    end
    res_mean_r <= res_mean_nxt;
    res_err_r  <= res_err_nxt;
    if (load_out) begin
      out_item_r.mean_concentration <= res_mean_r;
      out_item_r.window_error       <= res_err_r;
    end
  end

  `OWA_ASSERT_IMPLY(a_fill_bounded, win_ok, fill_r <= window_length_r)
  `OWA_ASSERT_IMPLY(a_div_done_in_div, div_status.done, state_r == S_DIV)
  `OWA_ASSERT_IMPLY(a_div_busy_in_div, div_status.busy, state_r == S_DIV)
  `OWA_ASSERT_IMPLY(a_error_mean_zero, out_valid && out_item.window_error,
                    out_item.mean_concentration == '0)
  `OWA_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state_r == S_READ || state_r == S_DONE)

endmodule

`default_nettype wire

// ----- tb/sv/window_mean_checker.sv -----
`timescale 1ns / 100ps

module window_mean_checker #(
  parameter int MAX_WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  owa_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  owa_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [owa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owa_pkg::KEY_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            outstanding
);

  import owa_pkg::*;

  localparam longint unsigned DEFAULT_NUM = 209;
  localparam longint unsigned DEFAULT_DEN = 1200;
  localparam longint unsigned CODED_DEN   = 1000;
  localparam int REPORT_LIMIT = 10;

  logic [SAMPLE_W-1:0] ring [0:MAX_WINDOW-1];
  logic [SUM_W-1:0]    win_sum;
  logic [WIN_W-1:0]    fill;
  logic [WIN_W-1:0]    slot;
  logic [WIN_W-1:0]    win_len;
  logic [KEY_W-1:0]    key;
  out_item_t           expected_means [$];
  int                  fail_tally = 0;

  function automatic out_item_t average_reading(input in_item_t rd);
    out_item_t           res;
    logic [SAMPLE_W-1:0] raw;
    longint unsigned     kn, kd, num, den, q;
    res = '0;
    if (win_len == '0 || win_len > MAX_WINDOW) begin
      res.window_error = 1'b1;
      return res;
    end
    raw = SAMPLE_W'(100 * rd.whole_part + 10 * rd.tenths_part + rd.hundredths_part);
    if (slot >= win_len) slot = '0;
    // drop the oldest reading once the window is full
    if (fill >= win_len) begin
      win_sum = win_sum - SUM_W'(ring[slot]);
      fill = win_len;
    end else begin
      fill = fill + 1'b1;
    end
    win_sum = win_sum + SUM_W'(raw);
    ring[slot] = raw;
    slot = (slot + 1'b1 >= win_len) ? '0 : slot + 1'b1;
    kn = (key == '0) ? DEFAULT_NUM : longint'(key);
    kd = (key == '0) ? DEFAULT_DEN : CODED_DEN;
    num = win_sum;
    num = num * kn;
    den = fill;
    den = den * kd;
    q = (den != 0) ? num / den : 0;
    if (q > MEAN_MAX) q = MEAN_MAX;
    res.mean_concentration = MEAN_W'(q);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      win_sum = '0;
      fill = '0;
      slot = '0;
      win_len = WINDOW_RESET;
      key = KEY_RESET;
      expected_means.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW) begin
          win_len = cfg_data[WIN_W-1:0];
          win_sum = '0;
          fill = '0;
          slot = '0;
        end else if (cfg_index == REG_KEY) begin
          key = cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          fail_tally++;
          if (fail_tally <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: mean %0d err %0b", $realtime,
                     out_item.mean_concentration, out_item.window_error);
        end else begin
          want = expected_means.pop_front();
          if (out_item.mean_concentration !== want.mean_concentration ||
              out_item.window_error !== want.window_error) begin
            fail_tally++;
            if (fail_tally <= REPORT_LIMIT)
              $display("%0t: mismatch: mean exp %0d got %0d, err exp %0b got %0b",
                       $realtime, want.mean_concentration, out_item.mean_concentration,
                       want.window_error, out_item.window_error);
          end
        end
      end
      if (in_valid && !in_stall) expected_means.push_back(average_reading(in_item));
    end
    mismatch_count <= fail_tally;
    outstanding <= expected_means.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import owa_pkg::*;

  localparam int MAX_WINDOW      = 100;
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int RANDOM_READINGS = 2000;
  localparam int SETTLE_CYCLES   = 50;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   outstanding;

  int hold_asked = 0;
  int readings_sent = 0;
  int reg_writes = 0;
  int bad_windows = 0;
  int cur_window = WINDOW_RESET;
  int cycles = 0;

  oxygen_window_averager #(.MAX_WINDOW(MAX_WINDOW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  window_mean_checker #(.MAX_WINDOW(MAX_WINDOW)) mean_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic in_item_t random_reading();
    in_item_t rd;
    int       pick;
    pick = $urandom_range(0, 19);
    rd.whole_part = 8'($urandom);
    rd.tenths_part = 8'($urandom);
    rd.hundredths_part = 8'($urandom);
    if (pick == 0) rd = '1;
    else if (pick == 1) rd = '0;
    else if (pick == 2) rd.whole_part = '1;
    return rd;
  endfunction

  task automatic send_reading(input in_item_t rd);
    in_valid <= 1'b1;
    in_item <= rd;
    do @(posedge clk); while (in_stall);
    readings_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_WINDOW) begin
      cur_window = data[WIN_W-1:0];
      if (cur_window == 0 || cur_window > MAX_WINDOW) begin
        bad_windows++;
        cur_window = 0;
      end
    end
  endtask

  // cycle watchdog
  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, calm stretches and requested long holds
  initial begin
    int  hold_served, stall_left, mode_left;
    bit  calm;
    hold_served = 0;
    stall_left = 0;
    mode_left = 0;
    calm = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          calm = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else if (calm) begin
          out_stall <= 1'b0;
        end else begin
          stall_left = gap_len();
          out_stall <= (stall_left > 0);
          if (stall_left > 0) stall_left--;
        end
      end
    end
  end

  initial begin
    int       n, g, r;
    bit       sender_calm;
    logic [KEY_W-1:0] wdata;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: window 20, default key
    send_reading({8'd0, 8'd0, 8'd0});
    send_reading({8'd255, 8'd255, 8'd255});
    send_reading({8'd255, 8'd0, 8'd0});
    send_reading({8'd0, 8'd255, 8'd0});
    send_reading({8'd0, 8'd0, 8'd255});
    send_reading({8'hAA, 8'h55, 8'hAA});
    send_reading({8'h55, 8'hAA, 8'h55});
    // largest key, one-reading window
    write_reg(REG_KEY, 8'd255);
    write_reg(REG_WINDOW, 8'd1);
    send_reading({8'd255, 8'd255, 8'd255});
    send_reading({8'd0, 8'd0, 8'd1});
    // invalid windows
    write_reg(REG_WINDOW, 8'd0);
    send_reading({8'd1, 8'd2, 8'd3});
    write_reg(REG_WINDOW, 8'd127);
    send_reading({8'd9, 8'd9, 8'd9});
    write_reg(REG_WINDOW, 8'(MAX_WINDOW + 1));
    send_reading({8'd200, 8'd1, 8'd7});
    // top data bit ignored: window 3, then wrap
    write_reg(REG_WINDOW, 8'h83);
    write_reg(REG_KEY, 8'd1);
    repeat (5) send_reading(random_reading());
    // key change keeps the history
    write_reg(REG_KEY, KEY_RESET);
    repeat (2) send_reading(random_reading());
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h01);
    send_reading(random_reading());
    write_reg(REG_WINDOW, 8'(MAX_WINDOW));
    repeat (3) send_reading(random_reading());

    // long receiver hold: fill the block until it stalls its input
    write_reg(REG_WINDOW, 8'd8);
    write_reg(REG_KEY, 8'd100);
    hold_asked <= hold_asked + 1;
    repeat (16) send_reading(random_reading());
    wait_drain();

    n = 0;
    while (n < RANDOM_READINGS) begin
      r = $urandom_range(0, 99);
      if (r < 60) wdata = 8'($urandom_range(1, 12));
      else if (r < 75) wdata = 8'($urandom_range(13, MAX_WINDOW - 10));
      else if (r < 88) wdata = 8'($urandom_range(MAX_WINDOW - 9, MAX_WINDOW));
      else if (r < 91) wdata = '0;
      else if (r < 94) wdata = 8'($urandom_range(MAX_WINDOW + 1, 127));
      else wdata = '1;
      wdata[KEY_W-1] = 1'($urandom);
      if (wdata != '1) write_reg(REG_WINDOW, wdata);
      r = $urandom_range(0, 9);
      if (r < 2) write_reg(REG_KEY, KEY_RESET);
      else if (r == 2) write_reg(REG_KEY, '1);
      else if (r == 3) write_reg(REG_KEY, 8'd1);
      else if (r < 8) write_reg(REG_KEY, 8'($urandom));
      if ($urandom_range(0, 19) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_asked <= hold_asked + 1;
      g = $urandom_range(5, 40) + cur_window;
      repeat (g) begin
        send_reading(random_reading());
        n++;
        if ($urandom_range(0, 49) == 0) begin
          wait_drain();
        end else begin
          r = sender_calm ? 0 : gap_len();
          if (r > 0) begin
            in_valid <= 1'b0;
            repeat (r) @(posedge clk);
          end
        end
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d readings across %0d register writes, %0d of them invalid windows.",
             readings_sent, reg_writes, bad_windows);
    $display("Result side held off for long stretches %0d times.", hold_asked);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
